@@ hw/rtl/cspa_pkg.sv @@
// Shared constants and types for the checked signed product accumulator.
package cspa_pkg;

	localparam int unsigned DataW = 64;
	localparam int unsigned HalfW = DataW / 2;

	// Magnitude of the most negative value, also the largest legal magnitude
	localparam logic [DataW-1:0] MagLimit = {1'b1, {(DataW-1){1'b0}}};
	localparam logic [DataW-1:0] MagOne   = {{(DataW-1){1'b0}}, 1'b1};

	// Result status codes
	localparam logic StatusOk       = 1'b0;
	localparam logic StatusOverflow = 1'b1;

	// Outcome of folding one factor into the running magnitude
	typedef struct packed {
		logic             is_zero;
		logic             is_neg;
		logic             mul_ovf;
		logic [DataW-1:0] mag_next;
	} step_t;

	// One result item
	typedef struct packed {
		logic [DataW-1:0] product;
		logic             status;
	} result_t;

endpackage

@@ hw/rtl/cspa_mag_mul.sv @@
// Factor magnitude and overflow-checked multiply into the running magnitude.
module cspa_mag_mul (
	input  logic [cspa_pkg::DataW-1:0] factor,
	input  logic [cspa_pkg::DataW-1:0] running,
	output cspa_pkg::step_t            step
);

	localparam int unsigned W = cspa_pkg::DataW;
	localparam int unsigned H = cspa_pkg::HalfW;

	logic [W-1:0]   mag;
	logic [H-1:0]   small_op;
	logic [W-1:0]   big_op;
	logic           both_wide;
	logic [W-1:0]   p_lo;
	logic [W-1:0]   p_hi;
	logic [W+H-1:0] full;

	// Take the magnitude; the most negative value wraps to 2^63 as intended
	assign mag = factor[W-1] ? (~factor + cspa_pkg::MagOne) : factor;

	// Pick the operand that fits in a half word; both wide means certain overflow
	always_comb begin
		both_wide = 1'b0;
		if (running[W-1:H] == '0) begin
			small_op = running[H-1:0];
			big_op   = mag;
		end else begin
			small_op = mag[H-1:0];
			big_op   = running;
			both_wide = (mag[W-1:H] != '0);
		end
	end

	// Split the wide operand into two half-word products
	assign p_lo = W'(small_op) * W'(big_op[H-1:0]);
	assign p_hi = W'(small_op) * W'(big_op[W-1:H]);
	assign full = {p_hi, {H{1'b0}}} + {{H{1'b0}}, p_lo};

	// Classify the factor and flag a product past the magnitude limit
	always_comb begin
		step.is_zero  = (factor == '0);
		step.is_neg   = factor[W-1];
		step.mul_ovf  = both_wide || (full[W+H-1:W] != '0) || (full[W-1:0] > cspa_pkg::MagLimit);
		step.mag_next = full[W-1:0];
	end

endmodule

@@ hw/rtl/cspa_out_reg.sv @@
// Result register that holds one item until the consumer takes it.
module cspa_out_reg (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       load,
	input  cspa_pkg::result_t          result,
	output logic                       room,
	output logic                       out_valid,
	input  logic                       out_stall,
	output logic [cspa_pkg::DataW-1:0] product,
	output logic                       status
);

	logic              valid_q;
	cspa_pkg::result_t data_q;

	// Free when empty or when the held item leaves this cycle
	assign room = !valid_q || !out_stall;

	// Track occupancy
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (room) begin
			valid_q <= load;
		end
	end

	// Capture payload
	always_ff @(posedge clk) begin
		if (room && load) begin
			data_q <= result;
		end
	end

	assign out_valid = valid_q;
	assign product   = data_q.product;
	assign status    = data_q.status;

endmodule

@@ hw/rtl/checked_signed_product_accumulator.sv @@
// Top level: overflow-checked signed product over runs of 64-bit factors.
//
//  Channel | Direction | Handshake           | Payload
//  --------+-----------+---------------------+-------------------------------
//  input   | in        | in_valid / in_stall | factor[63:0], last_factor
//  output  | out       | out_valid/out_stall | product[63:0], status
//
// One factor per cycle unless in_stall is high; the multiply and overflow check sit
// between the input register and the running-magnitude register, so no other register
// is in the running state loop. A result passes the input, then the result register.
// Reset (arst_n low) empties both registers and sets the magnitude to one.
// A stalled output blocks only a last factor; other factors keep flowing.
module checked_signed_product_accumulator (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       in_valid,
	output logic                       in_stall,
	input  logic [cspa_pkg::DataW-1:0] factor,
	input  logic                       last_factor,
	output logic                       out_valid,
	input  logic                       out_stall,
	output logic [cspa_pkg::DataW-1:0] product,
	output logic                       status
);

	localparam int unsigned W = cspa_pkg::DataW;

	logic              valid_s1;
	logic [W-1:0]      factor_s1;
	logic              last_s1;
	logic [W-1:0]      mag_q;
	logic              sign_q;
	logic              zero_q;
	logic              ovf_q;
	logic              room;
	logic              go_s1;
	logic              fire_s1;
	logic              in_fire;
	cspa_pkg::step_t   step;
	logic [W-1:0]      mag_nx;
	logic              sign_nx;
	logic              zero_nx;
	logic              ovf_nx;
	cspa_pkg::result_t result;

	// Advance the staged item unless it is a last item facing a full output
	assign go_s1    = !last_s1 || room;
	assign fire_s1  = valid_s1 && go_s1;
	assign in_stall = valid_s1 && !go_s1;
	assign in_fire  = in_valid && !in_stall;

	// Input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_fire) begin
			valid_s1 <= 1'b1;
		end else if (fire_s1) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_fire) begin
			factor_s1 <= factor;
			last_s1   <= last_factor;
		end
	end

	cspa_mag_mul u_mag_mul (
		.factor  (factor_s1),
		.running (mag_q),
		.step    (step)
	);

	// Fold the staged factor into the running state
	always_comb begin
		zero_nx = zero_q || step.is_zero;
		sign_nx = sign_q ^ (step.is_neg && !step.is_zero);
		ovf_nx  = ovf_q || (!step.is_zero && step.mul_ovf);
		mag_nx  = (!step.is_zero && !ovf_q && !step.mul_ovf) ? step.mag_next : mag_q;
	end

	// Form the run result from the updated state
	always_comb begin
		if (zero_nx) begin
			result.product = '0;
			result.status  = cspa_pkg::StatusOk;
		end else if (ovf_nx || (!sign_nx && (mag_nx == cspa_pkg::MagLimit))) begin
			result.product = '0;
			result.status  = cspa_pkg::StatusOverflow;
		end else if (sign_nx) begin
			result.product = ~mag_nx + cspa_pkg::MagOne;
			result.status  = cspa_pkg::StatusOk;
		end else begin
			result.product = mag_nx;
			result.status  = cspa_pkg::StatusOk;
		end
	end

	// Running state; clear at the end of each run
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mag_q  <= cspa_pkg::MagOne;
			sign_q <= 1'b0;
			zero_q <= 1'b0;
			ovf_q  <= 1'b0;
		end else if (fire_s1) begin
			if (last_s1) begin
				mag_q  <= cspa_pkg::MagOne;
				sign_q <= 1'b0;
				zero_q <= 1'b0;
				ovf_q  <= 1'b0;
			end else begin
				mag_q  <= mag_nx;
				sign_q <= sign_nx;
				zero_q <= zero_nx;
				ovf_q  <= ovf_nx;
			end
		end
	end

	cspa_out_reg u_out_reg (
		.clk       (clk),
		.arst_n    (arst_n),
		.load      (valid_s1 && last_s1),
		.result    (result),
		.room      (room),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.product   (product),
		.status    (status)
	);

endmodule
